@@ hw/rtl/erws_pkg.sv @@
package erws_pkg;

   // Fixed field widths of the request and result items.
   localparam int HANDLE_W = 32;
   localparam int SIZE_W   = 16;
   localparam int OFFSET_W = 20;
   localparam int SLOT_W   = 4;

   // Operation codes carried in the func field.
   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_SEEK = 1'b1;

   typedef struct packed {
      logic                func;
      logic [HANDLE_W-1:0] entry_handle;
      logic [SIZE_W-1:0]   entry_size;
      logic [OFFSET_W-1:0] seek_offset;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [SLOT_W-1:0]   found_slot;
      logic [HANDLE_W-1:0] found_handle;
      logic [SIZE_W-1:0]   byte_in_entry;
      logic                evicted;
      logic [HANDLE_W-1:0] evicted_handle;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_SEEK,
      ST_DONE
   } state_type;

endpackage

@@ hw/rtl/erws_chan_if.sv @@
interface erws_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

@@ hw/rtl/entry_ring_with_offset_seek.sv @@
// Overwriting ring of DEPTH descriptors (handle and byte size) with byte-offset seek.
// Requests arrive on req_chan, one item per handshake: func selects an add or a seek.
// Every request gives exactly one result item on rsp_chan.
// An add writes the descriptor at the write slot; when the ring was already full the
// oldest handle is reported as evicted and the read slot moves on. An add passes through
// ST_ADD_RD, ST_ADD_WR and ST_DONE before its result shows on rsp_chan.
// A seek walks the stored entries oldest first, one slot per cycle through the size
// memory read port, and reads at most count slots, where count is the number of stored
// entries (at most DEPTH).
// One item is worked at a time; req_chan.ready is high while the block is idle.
// Results sit in an output register: a stalled receiver holds the result there, and
// the block takes the next item as soon as the result has moved into that register.
// Reset (synchronous) empties the ring; the descriptor memories keep their contents,
// but only stored entries are ever read back.
module entry_ring_with_offset_seek #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   erws_chan_if.sink         req_chan,
   erws_chan_if.source       rsp_chan
);

   import erws_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
      return (i == LAST_SLOT) ? '0 : i + 1'b1;
   endfunction

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                full_ff, full_in;
   logic [HANDLE_W-1:0] add_handle_ff, add_handle_in;
   logic [SIZE_W-1:0]   add_size_ff, add_size_in;
   logic [OFFSET_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0]    issue_slot_ff, issue_slot_in;
   logic [CNT_W-1:0]    issue_left_ff, issue_left_in;
   logic                chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]    chk_slot_ff, chk_slot_in;
   rsp_type             res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                accept;
   logic                out_free;
   logic                hit;
   logic [CNT_W-1:0]    stored_count;
   logic                ram_wr;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic [HANDLE_W-1:0] rd_handle;
   logic [SIZE_W-1:0]   rd_size;

   // Descriptor storage: handles and sizes share addresses.
   erws_ram #(.WIDTH(HANDLE_W), .DEPTH(DEPTH)) u_handle_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (wr_idx_ff),
      .wr_data (add_handle_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_handle)
   );

   erws_ram #(.WIDTH(SIZE_W), .DEPTH(DEPTH)) u_size_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (wr_idx_ff),
      .wr_data (add_size_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_size)
   );

   // Number of stored entries, oldest at the read slot.
   always_comb begin
      if (full_ff) begin
         stored_count = CNT_W'(DEPTH);
      end else if (wr_idx_ff >= rd_idx_ff) begin
         stored_count = CNT_W'(wr_idx_ff) - CNT_W'(rd_idx_ff);
      end else begin
         stored_count = CNT_W'(wr_idx_ff) + CNT_W'(DEPTH) - CNT_W'(rd_idx_ff);
      end
   end

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign hit      = chk_valid_ff && (rem_ff < OFFSET_W'(rd_size));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = (req_chan.payload.func == FUNC_SEEK) ? ST_SEEK : ST_ADD_RD;
            end
         end
         ST_ADD_RD: state_in = ST_ADD_WR;
         ST_ADD_WR: state_in = ST_DONE;
         ST_SEEK: begin
            if (hit || (!chk_valid_ff && issue_left_ff == '0)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      ram_wr         = 1'b0;
      ram_rd_addr    = rd_idx_ff;
      wr_idx_in      = wr_idx_ff;
      rd_idx_in      = rd_idx_ff;
      full_in        = full_ff;
      add_handle_in  = add_handle_ff;
      add_size_in    = add_size_ff;
      rem_in         = rem_ff;
      issue_slot_in  = issue_slot_ff;
      issue_left_in  = issue_left_ff;
      chk_valid_in   = 1'b0;
      chk_slot_in    = chk_slot_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_IDLE: begin
            // Capture the item and set up a walk from the oldest entry.
            if (accept) begin
               add_handle_in = req_chan.payload.entry_handle;
               add_size_in   = req_chan.payload.entry_size;
               rem_in        = req_chan.payload.seek_offset;
               issue_slot_in = rd_idx_ff;
               issue_left_in = stored_count;
            end
         end
         ST_ADD_WR: begin
            // The oldest handle was read last cycle; now store the new entry.
            ram_wr                = 1'b1;
            res_in                = '0;
            res_in.evicted        = full_ff;
            res_in.evicted_handle = full_ff ? rd_handle : '0;
            wr_idx_in             = next_slot(wr_idx_ff);
            rd_idx_in             = full_ff ? next_slot(rd_idx_ff) : rd_idx_ff;
            full_in               = full_ff || (next_slot(wr_idx_ff) == rd_idx_in);
         end
         ST_SEEK: begin
            // Issue one read a cycle and check the entry read the cycle before.
            ram_rd_addr = issue_slot_ff;
            if (issue_left_ff != '0) begin
               issue_slot_in = next_slot(issue_slot_ff);
               issue_left_in = issue_left_ff - 1'b1;
               chk_valid_in  = 1'b1;
               chk_slot_in   = issue_slot_ff;
            end
            if (hit) begin
               res_in               = '0;
               res_in.found         = 1'b1;
               res_in.found_slot    = SLOT_W'(chk_slot_ff);
               res_in.found_handle  = rd_handle;
               res_in.byte_in_entry = rem_ff[SIZE_W-1:0];
            end else if (chk_valid_ff) begin
               rem_in = rem_ff - OFFSET_W'(rd_size);
            end else if (issue_left_ff == '0) begin
               res_in = '0;
            end
         end
         ST_DONE: begin
            // Move the result into the output register once it is free.
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         full_ff       <= 1'b0;
         chk_valid_ff  <= 1'b0;
         issue_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_idx_ff     <= wr_idx_in;
         rd_idx_ff     <= rd_idx_in;
         full_ff       <= full_in;
         chk_valid_ff  <= chk_valid_in;
         issue_left_ff <= issue_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      add_handle_ff <= add_handle_in;
      add_size_ff   <= add_size_in;
      rem_ff        <= rem_in;
      issue_slot_ff <= issue_slot_in;
      chk_slot_ff   <= chk_slot_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // A full ring always has its write slot on top of the oldest entry.
   a_full_aligned: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (wr_idx_ff == rd_idx_ff))
      else $error("ring full with write and read slots apart");

   // Overwriting the oldest entry moves the read slot on.
   a_evict_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD_WR) && full_ff |=> (rd_idx_ff != $past(rd_idx_ff)))
      else $error("eviction left the read slot in place");

   // A result is either a seek hit or an eviction, never both.
   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.payload.found && rsp_chan.payload.evicted))
      else $error("result marked both found and evicted");

endmodule

@@ hw/rtl/erws_ram.sv @@
module erws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one read port with the read data registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
